// ----- sv/ppm_inv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_inv_pkg
// Shared types and constants for the ASCII PPM color inverter.
// ----------------------------------------------------------------------------
package ppm_inv_pkg;

	// Header and payload widths
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned FIELD_W    = 16;
	localparam int unsigned CHAN_W     = 2;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned OUT_DATA_W = 72;

	// Output tdata layout, lowest bit first
	localparam int unsigned SAMPLE_LSB = 0;
	localparam int unsigned CHAN_LSB   = SAMPLE_LSB + FIELD_W;
	localparam int unsigned WIDTH_LSB  = CHAN_LSB + CHAN_W;
	localparam int unsigned HEIGHT_LSB = WIDTH_LSB + FIELD_W;
	localparam int unsigned MAXC_LSB   = HEIGHT_LSB + FIELD_W;
	localparam int unsigned PAD_LSB    = MAXC_LSB + FIELD_W;
	localparam int unsigned PAD_W      = OUT_DATA_W - PAD_LSB;

	// Characters
	localparam logic [BYTE_W-1:0] CH_THREE   = 8'h33;
	localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;

	// Last color channel before wrapping back to red
	localparam logic [CHAN_W-1:0] CHAN_BLUE = 2'd2;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_WIDTH,
		PH_HEIGHT,
		PH_MAXC,
		PH_SAMPLES,
		PH_STOPPED
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE,
		KIND_HEADER,
		KIND_BADFMT
	} kind_t;

endpackage
`default_nettype wire

// ----- sv/ascii_ppm_color_inverter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_ppm_color_inverter
// Byte-serial P3 PPM parser that reports the header and inverted samples, and flags unsupported formats.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one file character per transaction in s_tdata; s_tuser
//   high marks the first byte of a new file and restarts all parsing.
//   Master side gives at most one result per input byte: m_tuser holds the
//   kind (inverted sample, header complete, unsupported format), m_tdata the
//   sample, its channel and the stored width, height and max color.
//   Throughput is one byte per cycle while the receiver does not stall, set
//   by the single-pass update of the parser state (decimal accumulate is a
//   shift-add times ten). A byte that ends a number (or the magic line)
//   passes through the input register and then the result register before
//   m_tvalid rises.
//   Reset (arst_n low) returns to the magic-line phase with all stored
//   header values zero. When the receiver stalls, the result register holds
//   and the input register fills; s_tready drops only once both are full.
// ----------------------------------------------------------------------------
module ascii_ppm_color_inverter
	import ppm_inv_pkg::*;
#(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,  // file_byte
	input  wire logic                  s_tuser,  // start_of_file
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // sample_value, color_channel,
	                                             // image_width, image_height,
	                                             // max_color, zero pad
	output logic [KIND_W-1:0]          m_tuser   // result_kind
);

	localparam int unsigned SB  = SAMPLE_BITS;
	localparam int unsigned PW  = SAMPLE_BITS + 4;

	// Input register
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              sof_s1;

	// Parser state
	phase_t          phase_q;
	logic [SB-1:0]   acc_q;
	logic            innum_q;
	logic            lstart_q;
	logic            incmt_q;
	logic [SB-1:0]   width_q;
	logic [SB-1:0]   height_q;
	logic [SB-1:0]   maxc_q;
	logic [CHAN_W-1:0] chan_q;

	// Result register
	logic              v_s2;
	kind_t             kind_s2;
	logic [SB-1:0]     sample_s2;
	logic [CHAN_W-1:0] chan_s2;
	logic [SB-1:0]     width_s2;
	logic [SB-1:0]     height_s2;
	logic [SB-1:0]     maxc_s2;

	// Next-state and result logic
	phase_t            phase_w, phase_n;
	logic [SB-1:0]     acc_w, acc_n;
	logic              innum_w, innum_n;
	logic              lstart_w, lstart_n;
	logic              incmt_w, incmt_n;
	logic [SB-1:0]     width_w, width_n;
	logic [SB-1:0]     height_w, height_n;
	logic [SB-1:0]     maxc_w, maxc_n;
	logic [CHAN_W-1:0] chan_w, chan_n;
	logic              emit;
	kind_t             kind_n;
	logic [SB-1:0]     sample_n;
	logic [CHAN_W-1:0] rchan_n;
	logic              is_digit;
	logic              is_nl;
	logic [PW-1:0]     prod;
	logic              adv;

	assign adv      = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv;

	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_nl    = (byte_s1 == CH_NEWLINE);

	// acc * 10 + digit, digit is the low nibble of an ASCII digit
	assign prod = ({{4{1'b0}}, acc_w} << 3) + ({{4{1'b0}}, acc_w} << 1)
		+ {{(PW-4){1'b0}}, byte_s1[3:0]};

	always_comb begin
		// start of file clears everything before the byte is used
		if (sof_s1) begin
			phase_w  = PH_MAGIC;
			acc_w    = '0;
			innum_w  = 1'b0;
			lstart_w = 1'b1;
			incmt_w  = 1'b0;
			width_w  = '0;
			height_w = '0;
			maxc_w   = '0;
			chan_w   = '0;
		end else begin
			phase_w  = phase_q;
			acc_w    = acc_q;
			innum_w  = innum_q;
			lstart_w = lstart_q;
			incmt_w  = incmt_q;
			width_w  = width_q;
			height_w = height_q;
			maxc_w   = maxc_q;
			chan_w   = chan_q;
		end

		phase_n  = phase_w;
		acc_n    = acc_w;
		innum_n  = innum_w;
		lstart_n = is_nl;
		incmt_n  = incmt_w;
		width_n  = width_w;
		height_n = height_w;
		maxc_n   = maxc_w;
		chan_n   = chan_w;
		emit     = 1'b0;
		kind_n   = KIND_SAMPLE;
		sample_n = '0;
		rchan_n  = '0;

		if (phase_w == PH_STOPPED) begin
			// ignore until next file
		end else if (phase_w != PH_SAMPLES && incmt_w) begin
			if (is_nl) begin
				incmt_n = 1'b0;
			end
		end else if (phase_w != PH_SAMPLES && lstart_w && byte_s1 == CH_HASH) begin
			incmt_n = 1'b1;
		end else if (phase_w == PH_MAGIC) begin
			// acc counts line characters (saturating at 2); innum flags a '3' second
			if (is_nl) begin
				if (innum_w) begin
					phase_n = PH_WIDTH;
				end else begin
					phase_n = PH_STOPPED;
					emit    = 1'b1;
					kind_n  = KIND_BADFMT;
				end
				acc_n   = '0;
				innum_n = 1'b0;
			end else begin
				if (acc_w == SB'(1) && byte_s1 == CH_THREE) begin
					innum_n = 1'b1;
				end
				if (acc_w < SB'(2)) begin
					acc_n = acc_w + SB'(1);
				end
			end
		end else if (is_digit) begin
			if (!innum_w) begin
				acc_n = {{(SB-4){1'b0}}, byte_s1[3:0]};
			end else if (prod > {{4{1'b0}}, {SB{1'b1}}}) begin
				acc_n = '1;
			end else begin
				acc_n = prod[SB-1:0];
			end
			innum_n = 1'b1;
		end else if (innum_w) begin
			innum_n = 1'b0;
			acc_n   = '0;
			unique case (phase_w)
				PH_WIDTH: begin
					width_n = acc_w;
					phase_n = PH_HEIGHT;
				end
				PH_HEIGHT: begin
					height_n = acc_w;
					phase_n  = PH_MAXC;
				end
				PH_MAXC: begin
					maxc_n  = acc_w;
					phase_n = PH_SAMPLES;
					chan_n  = '0;
					emit    = 1'b1;
					kind_n  = KIND_HEADER;
				end
				default: begin
					emit     = 1'b1;
					kind_n   = KIND_SAMPLE;
					sample_n = (acc_w > maxc_w) ? '0 : maxc_w - acc_w;
					rchan_n  = chan_w;
					chan_n   = (chan_w >= CHAN_BLUE) ? '0 : chan_w + CHAN_W'(1);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			acc_q    <= '0;
			innum_q  <= 1'b0;
			lstart_q <= 1'b1;
			incmt_q  <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			maxc_q   <= '0;
			chan_q   <= '0;
		end else if (v_s1 && adv) begin
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			innum_q  <= innum_n;
			lstart_q <= lstart_n;
			incmt_q  <= incmt_n;
			width_q  <= width_n;
			height_q <= height_n;
			maxc_q   <= maxc_n;
			chan_q   <= chan_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && emit) begin
			kind_s2   <= kind_n;
			sample_s2 <= sample_n;
			chan_s2   <= rchan_n;
			width_s2  <= width_n;
			height_s2 <= height_n;
			maxc_s2   <= maxc_n;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {
		{PAD_W{1'b0}},
		FIELD_W'(maxc_s2),
		FIELD_W'(height_s2),
		FIELD_W'(width_s2),
		chan_s2,
		FIELD_W'(sample_s2)
	};

endmodule
`default_nettype wire

// ----- sv/ppm_inv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppm_inv_checker
// Port-level checks for the ASCII PPM color inverter.
// ----------------------------------------------------------------------------
module ppm_inv_checker
	import ppm_inv_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic [BYTE_W-1:0]     s_tdata,
	input wire logic                  s_tuser,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [KIND_W-1:0]     m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// inverted sample never exceeds the reported max color
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SAMPLE |->
		m_tdata[SAMPLE_LSB +: FIELD_W] <= m_tdata[MAXC_LSB +: FIELD_W])
		else $error("sample above max color");

	// header and format results carry no sample or channel
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_SAMPLE |->
		m_tdata[SAMPLE_LSB +: FIELD_W] == '0 && m_tdata[CHAN_LSB +: CHAN_W] == '0)
		else $error("non-sample result with sample fields");

	// a sample result's channel is red, green or blue
	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SAMPLE |-> m_tdata[CHAN_LSB +: CHAN_W] != 2'd3)
		else $error("bad color channel");

	// the parser keeps taking bytes while the result side is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind ascii_ppm_color_inverter ppm_inv_checker u_ppm_inv_checker (.*);
`default_nettype wire
